// ===== design/pwb_pkg.sv =====
package pwb_pkg;

	localparam int COEF_W = 32;
	localparam int PROD_W = 41;
	localparam int MAG_W = 42;
	localparam int FRAC_W = 16;
	localparam int DIVD_W = MAG_W + FRAC_W;
	localparam int CH_W = 8;
	localparam int NCH = 4;
	localparam int PIX_W = CH_W * NCH;
	localparam int FR_W = FRAC_W + 1;
	localparam int TOP_W = 28;
	localparam int DIFF_W = TOP_W + 1;
	localparam int V_W = 48;
	localparam int CFG_W = 64;
	localparam int CFG_AW = 3;
	localparam logic [MAG_W-1:0] ONE_Q16 = MAG_W'(65536);
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [CFG_AW-1:0] {
		REG_ROW0_AB = 3'd0,
		REG_ROW0C_ROW1A = 3'd1,
		REG_ROW1_BC = 3'd2,
		REG_ROW2_AB = 3'd3,
		REG_ROW2_C = 3'd4,
		REG_IMG_W = 3'd5,
		REG_IMG_H = 3'd6
	} pwb_reg_t;

	typedef struct packed {
		logic kind;
		logic neg_x;
		logic neg_y;
		logic [7:0] wr_x;
		logic [7:0] wr_y;
		logic [PIX_W-1:0] pixel;
	} pwb_tag_t;

	typedef struct packed {
		logic x0;
		logic x1;
		logic y0;
		logic y1;
	} pwb_ok_t;

endpackage

// ===== design/pwb_div.sv =====
module pwb_div import pwb_pkg::*; #(
	parameter int TW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [TW-1:0] in_tag,
	input  logic [MAG_W-1:0] num_a,
	input  logic [MAG_W-1:0] num_b,
	input  logic [MAG_W-1:0] den,
	output logic out_valid,
	output logic [TW-1:0] out_tag,
	output logic [DIVD_W-1:0] quo_a,
	output logic [DIVD_W-1:0] quo_b
);

	// one quotient bit per stage, restoring, shared divisor
	logic vld_s [DIVD_W];
	logic [TW-1:0] tag_s [DIVD_W];
	logic [MAG_W-1:0] den_s [DIVD_W];
	logic [MAG_W-1:0] rem_a_s [DIVD_W];
	logic [MAG_W-1:0] rem_b_s [DIVD_W];
	logic [DIVD_W-1:0] sh_a_s [DIVD_W];
	logic [DIVD_W-1:0] sh_b_s [DIVD_W];

	genvar k;
	generate
		for (k = 0; k < DIVD_W; k++) begin : g_stage
			logic vi;
			logic [TW-1:0] ti;
			logic [MAG_W-1:0] di, rai, rbi;
			logic [DIVD_W-1:0] sai, sbi;
			logic [MAG_W:0] tra, trb;
			logic gea, geb;

			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ti = in_tag;
				assign di = den;
				assign rai = '0;
				assign rbi = '0;
				assign sai = {num_a, {FRAC_W{1'b0}}};
				assign sbi = {num_b, {FRAC_W{1'b0}}};
			end else begin : g_next
				assign vi = vld_s[k-1];
				assign ti = tag_s[k-1];
				assign di = den_s[k-1];
				assign rai = rem_a_s[k-1];
				assign rbi = rem_b_s[k-1];
				assign sai = sh_a_s[k-1];
				assign sbi = sh_b_s[k-1];
			end

			assign tra = {rai, sai[DIVD_W-1]};
			assign trb = {rbi, sbi[DIVD_W-1]};
			assign gea = tra >= {1'b0, di};
			assign geb = trb >= {1'b0, di};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				tag_s[k] <= ti;
				den_s[k] <= di;
				rem_a_s[k] <= gea ? MAG_W'(tra - {1'b0, di}) : tra[MAG_W-1:0];
				rem_b_s[k] <= geb ? MAG_W'(trb - {1'b0, di}) : trb[MAG_W-1:0];
				sh_a_s[k] <= {sai[DIVD_W-2:0], gea};
				sh_b_s[k] <= {sbi[DIVD_W-2:0], geb};
			end
		end
	endgenerate

	assign out_valid = vld_s[DIVD_W-1];
	assign out_tag = tag_s[DIVD_W-1];
	assign quo_a = sh_a_s[DIVD_W-1];
	assign quo_b = sh_b_s[DIVD_W-1];

endmodule

// ===== design/projective_warp_bilinear.sv =====
// Projective warp with bilinear sampling.
// Input: start with kind, coord_x, coord_y, pixel_in. busy is always low, so a
// transaction is taken on every cycle that start is high. kind 0 stores
// pixel_in at (coord_x, coord_y); kind 1 asks for the warped destination pixel.
// Output: done pulses for one cycle with pixel_out, after the request passes
// through 3 matrix stages, 58 divider stages and 6 sample and
// interpolate stages. Writes give no output. One transaction per cycle,
// sustained; set by the 58-stage pipelined quotient unit for X/W and Y/W.
// Writes travel down the same pipeline and hit the image store at the read
// stage, so a request sees exactly the writes taken before it.
// The store is four banks by column and row parity, so the four neighbours
// are read in the same cycle.
// Configuration: cfg_we, cfg_addr, cfg_wdata; write only while no request
// is in flight. Reset loads the identity matrix and a 256x256 image size;
// the image store is not cleared. The receiver cannot stall: done is a pulse.
module projective_warp_bilinear import pwb_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int CHANNELS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic kind,
	input  logic [7:0] coord_x,
	input  logic [7:0] coord_y,
	input  logic [PIX_W-1:0] pixel_in,
	output logic done,
	output logic [PIX_W-1:0] pixel_out,
	input  logic cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int HW = (MAX_WIDTH + 1) / 2;
	localparam int HH = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HW * HH;
	localparam int BIW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int LAT = 3 + DIVD_W + 6;

	function automatic logic [BIW-1:0] bank_index(input logic [31:0] row, input logic [31:0] col);
		logic [31:0] idx;
		idx = (row >> 1) * 32'(HW) + (col >> 1);
		return idx[BIW-1:0];
	endfunction

	// configuration
	logic [CFG_W-1:0] coef0_q, coef1_q, coef2_q, coef3_q;
	logic [COEF_W-1:0] coef4_q;
	logic [8:0] img_w_q, img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef0_q <= {32'h0001_0000, 32'h0};
			coef1_q <= '0;
			coef2_q <= {32'h0001_0000, 32'h0};
			coef3_q <= '0;
			coef4_q <= 32'h0001_0000;
			img_w_q <= 9'd256;
			img_h_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROW0_AB: coef0_q <= cfg_wdata;
				REG_ROW0C_ROW1A: coef1_q <= cfg_wdata;
				REG_ROW1_BC: coef2_q <= cfg_wdata;
				REG_ROW2_AB: coef3_q <= cfg_wdata;
				REG_ROW2_C: coef4_q <= cfg_wdata[COEF_W-1:0];
				REG_IMG_W: img_w_q <= cfg_wdata[8:0];
				REG_IMG_H: img_h_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// s1: products
	logic vld_s1, kind_s1;
	logic [7:0] x_s1, y_s1;
	logic [PIX_W-1:0] pix_s1;
	logic signed [PROD_W-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [8:0] xs, ys;

	assign xs = $signed({1'b0, coord_x});
	assign ys = $signed({1'b0, coord_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		x_s1 <= coord_x;
		y_s1 <= coord_y;
		pix_s1 <= pixel_in;
		p00_s1 <= $signed(coef0_q[63:32]) * xs;
		p01_s1 <= $signed(coef0_q[31:0]) * ys;
		p10_s1 <= $signed(coef1_q[31:0]) * xs;
		p11_s1 <= $signed(coef2_q[63:32]) * ys;
		p20_s1 <= $signed(coef3_q[63:32]) * xs;
		p21_s1 <= $signed(coef3_q[31:0]) * ys;
	end

	// s2: homogeneous sums
	logic vld_s2, kind_s2;
	logic [7:0] x_s2, y_s2;
	logic [PIX_W-1:0] pix_s2;
	logic signed [MAG_W-1:0] hx_s2, hy_s2, hw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		pix_s2 <= pix_s1;
		hx_s2 <= MAG_W'(p00_s1) + MAG_W'(p01_s1) + MAG_W'($signed(coef1_q[63:32]));
		hy_s2 <= MAG_W'(p10_s1) + MAG_W'(p11_s1) + MAG_W'($signed(coef2_q[31:0]));
		hw_s2 <= MAG_W'(p20_s1) + MAG_W'(p21_s1) + MAG_W'($signed(coef4_q));
	end

	// s3: magnitudes and signs; W of 0 divides by one
	logic vld_s3;
	pwb_tag_t tag_s3;
	logic [MAG_W-1:0] ax_s3, ay_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3.kind <= kind_s2;
		tag_s3.neg_x <= hx_s2[MAG_W-1] ^ hw_s2[MAG_W-1];
		tag_s3.neg_y <= hy_s2[MAG_W-1] ^ hw_s2[MAG_W-1];
		tag_s3.wr_x <= x_s2;
		tag_s3.wr_y <= y_s2;
		tag_s3.pixel <= pix_s2;
		ax_s3 <= hx_s2[MAG_W-1] ? MAG_W'(-hx_s2) : hx_s2;
		ay_s3 <= hy_s2[MAG_W-1] ? MAG_W'(-hy_s2) : hy_s2;
		den_s3 <= (hw_s2 == '0) ? ONE_Q16 : (hw_s2[MAG_W-1] ? MAG_W'(-hw_s2) : hw_s2);
	end

	// quotient pipeline
	logic dv_vld;
	pwb_tag_t dv_tag;
	logic [DIVD_W-1:0] qx, qy;

	pwb_div #(.TW($bits(pwb_tag_t))) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s3),
		.in_tag(tag_s3),
		.num_a(ax_s3),
		.num_b(ay_s3),
		.den(den_s3),
		.out_valid(dv_vld),
		.out_tag(dv_tag),
		.quo_a(qx),
		.quo_b(qy)
	);

	// s4: base point, fraction, bounds
	logic [MAG_W-1:0] ix, iy, bx, by, wlim, hlim;
	logic [FRAC_W-1:0] fxm, fym;
	pwb_ok_t ok_d;

	assign ix = qx[DIVD_W-1:FRAC_W];
	assign iy = qy[DIVD_W-1:FRAC_W];
	assign fxm = qx[FRAC_W-1:0];
	assign fym = qy[FRAC_W-1:0];
	assign bx = dv_tag.neg_x ? MAG_W'(-ix) : ix;
	assign by = dv_tag.neg_y ? MAG_W'(-iy) : iy;
	assign wlim = (32'(img_w_q) > MAX_WIDTH) ? MAG_W'(MAX_WIDTH) : MAG_W'(img_w_q);
	assign hlim = (32'(img_h_q) > MAX_HEIGHT) ? MAG_W'(MAX_HEIGHT) : MAG_W'(img_h_q);

	always_comb begin
		if (dv_tag.neg_x && ix != '0) begin
			ok_d.x0 = 1'b0;
			ok_d.x1 = (ix == MAG_W'(1)) && (wlim != '0);
		end else begin
			ok_d.x0 = ix < wlim;
			ok_d.x1 = ({1'b0, ix} + 1'b1) < {1'b0, wlim};
		end
		if (dv_tag.neg_y && iy != '0) begin
			ok_d.y0 = 1'b0;
			ok_d.y1 = (iy == MAG_W'(1)) && (hlim != '0);
		end else begin
			ok_d.y0 = iy < hlim;
			ok_d.y1 = ({1'b0, iy} + 1'b1) < {1'b0, hlim};
		end
	end

	logic vld_s4;
	pwb_tag_t tag_s4;
	pwb_ok_t ok_s4;
	logic [XW-1:0] c0x_s4;
	logic [YW-1:0] c0y_s4;
	logic signed [FR_W-1:0] fx_s4, fy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4 <= dv_tag;
		ok_s4 <= ok_d;
		c0x_s4 <= bx[XW-1:0];
		c0y_s4 <= by[YW-1:0];
		fx_s4 <= dv_tag.neg_x ? FR_W'(-$signed({1'b0, fxm})) : $signed({1'b0, fxm});
		fy_s4 <= dv_tag.neg_y ? FR_W'(-$signed({1'b0, fym})) : $signed({1'b0, fym});
	end

	// s5: bank addresses; bank b holds column parity b[0], row parity b[1]
	logic [XW-1:0] c1x;
	logic [YW-1:0] c1y;
	logic [31:0] wx32, wy32;
	logic [XW-1:0] wcol;
	logic [YW-1:0] wrow;
	logic wr_in;
	logic [BIW-1:0] addr_d [NCH];
	logic [3:0] we_d;

	assign c1x = XW'(c0x_s4 + 1'b1);
	assign c1y = YW'(c0y_s4 + 1'b1);
	assign wx32 = 32'(tag_s4.wr_x);
	assign wy32 = 32'(tag_s4.wr_y);
	assign wcol = wx32[XW-1:0];
	assign wrow = wy32[YW-1:0];
	assign wr_in = vld_s4 && !tag_s4.kind && (wx32 < 32'(MAX_WIDTH)) && (wy32 < 32'(MAX_HEIGHT));

	genvar gb;
	generate
		for (gb = 0; gb < 4; gb++) begin : g_addr
			localparam logic PX = (gb % 2) == 1;
			localparam logic PY = (gb / 2) == 1;
			logic [XW-1:0] cs;
			logic [YW-1:0] rs;

			assign cs = (c0x_s4[0] == PX) ? c0x_s4 : c1x;
			assign rs = (c0y_s4[0] == PY) ? c0y_s4 : c1y;
			assign addr_d[gb] = tag_s4.kind ? bank_index(32'(rs), 32'(cs))
				: bank_index(32'(wrow), 32'(wcol));
			assign we_d[gb] = wr_in && (wcol[0] == PX) && (wrow[0] == PY);
		end
	endgenerate

	logic rq_s5, px_s5, py_s5;
	logic [3:0] we_s5;
	logic [BIW-1:0] addr_s5 [NCH];
	logic [PIX_W-1:0] wdata_s5;
	pwb_ok_t ok_s5;
	logic signed [FR_W-1:0] fx_s5, fy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_s5 <= 1'b0;
			we_s5 <= '0;
		end else begin
			rq_s5 <= vld_s4 && tag_s4.kind;
			we_s5 <= we_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_s5 <= addr_d;
		wdata_s5 <= tag_s4.pixel;
		px_s5 <= c0x_s4[0];
		py_s5 <= c0y_s4[0];
		ok_s5 <= ok_s4;
		fx_s5 <= fx_s4;
		fy_s5 <= fy_s4;
	end

	// s6: image store banks, registered read
	logic [PIX_W-1:0] rd_s6 [NCH];

	generate
		for (gb = 0; gb < 4; gb++) begin : g_bank
			logic [PIX_W-1:0] mem [BANK_DEPTH];

			always_ff @(posedge clk) begin
				if (we_s5[gb]) begin
					mem[addr_s5[gb]] <= wdata_s5;
				end
				rd_s6[gb] <= mem[addr_s5[gb]];
			end
		end
	endgenerate

	logic rq_s6, px_s6, py_s6;
	pwb_ok_t ok_s6;
	logic signed [FR_W-1:0] fx_s6, fy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_s6 <= 1'b0;
		end else begin
			rq_s6 <= rq_s5;
		end
	end

	always_ff @(posedge clk) begin
		px_s6 <= px_s5;
		py_s6 <= py_s5;
		ok_s6 <= ok_s5;
		fx_s6 <= fx_s5;
		fy_s6 <= fy_s5;
	end

	logic [1:0] b00, b01, b10, b11;

	assign b00 = {py_s6, px_s6};
	assign b01 = {py_s6, !px_s6};
	assign b10 = {!py_s6, px_s6};
	assign b11 = {!py_s6, !px_s6};

	logic rq_s7, rq_s8, rq_s9;
	logic signed [FR_W-1:0] fy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_s7 <= 1'b0;
			rq_s8 <= 1'b0;
			rq_s9 <= 1'b0;
		end else begin
			rq_s7 <= rq_s6;
			rq_s8 <= rq_s7;
			rq_s9 <= rq_s8;
		end
	end

	always_ff @(posedge clk) begin
		fy_s7 <= fy_s6;
	end

	// s7..s9: per channel lerp in x, lerp in y, clamp
	logic [CH_W-1:0] chan_out [NCH];

	genvar gc;
	generate
		for (gc = 0; gc < NCH; gc++) begin : g_chan
			if (gc < CHANNELS) begin : g_used
				logic [CH_W-1:0] c00, c01, c10, c11;
				logic signed [8:0] d0, d1;
				logic signed [25:0] m0, m1;
				logic signed [TOP_W-1:0] base0, base1;
				logic signed [TOP_W-1:0] top_s7, bot_s7, top_s8;
				logic signed [DIFF_W-1:0] dtb;
				logic signed [V_W-1:0] p_s8, v;
				logic [CH_W-1:0] q_s9;

				assign c00 = ok_s6.x0 && ok_s6.y0 ? rd_s6[b00][gc*CH_W +: CH_W] : '0;
				assign c01 = ok_s6.x1 && ok_s6.y0 ? rd_s6[b01][gc*CH_W +: CH_W] : '0;
				assign c10 = ok_s6.x0 && ok_s6.y1 ? rd_s6[b10][gc*CH_W +: CH_W] : '0;
				assign c11 = ok_s6.x1 && ok_s6.y1 ? rd_s6[b11][gc*CH_W +: CH_W] : '0;
				assign d0 = $signed({1'b0, c01}) - $signed({1'b0, c00});
				assign d1 = $signed({1'b0, c11}) - $signed({1'b0, c10});
				assign m0 = d0 * fx_s6;
				assign m1 = d1 * fx_s6;
				assign base0 = {4'b0, c00, 16'h0};
				assign base1 = {4'b0, c10, 16'h0};
				assign dtb = DIFF_W'(bot_s7) - DIFF_W'(top_s7);
				assign v = (V_W'(top_s8) <<< FRAC_W) + p_s8;

				always_ff @(posedge clk) begin
					top_s7 <= base0 + TOP_W'(m0);
					bot_s7 <= base1 + TOP_W'(m1);
					top_s8 <= top_s7;
					p_s8 <= dtb * fy_s7;
					if (v[V_W-1]) begin
						q_s9 <= '0;
					end else if (v[V_W-2:32] > (V_W-33)'(CH_MAX)) begin
						q_s9 <= CH_MAX;
					end else begin
						q_s9 <= v[32 +: CH_W];
					end
				end

				assign chan_out[gc] = q_s9;
			end else begin : g_unused
				assign chan_out[gc] = '0;
			end
		end
	endgenerate

	assign done = rq_s9;
	assign pixel_out = {chan_out[3], chan_out[2], chan_out[1], chan_out[0]};

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && kind, LAT))
		else $error("result without matching request");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !kind, LAT) |-> !done)
		else $error("store write produced a result");

	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we_s5))
		else $error("more than one bank written");

	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		rq_s5 |-> we_s5 == '0)
		else $error("bank write during a sample read");

endmodule
